// ===== hdl/bse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Types, opcodes and sizes shared by the bytecode stack executor.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int DEPTH_W     = 7;
  localparam int LEFT_W      = 3;
  localparam int IMM_BYTES   = DATA_W / BYTE_W;

  // opcodes
  localparam logic [7:0] OP_BOOT  = 8'h01;
  localparam logic [7:0] OP_PUSH  = 8'h02;
  localparam logic [7:0] OP_ADD   = 8'h03;
  localparam logic [7:0] OP_SUB   = 8'h0E;
  localparam logic [7:0] OP_PEEK  = 8'h06;
  localparam logic [7:0] OP_CLEAR = 8'h08;
  localparam logic [7:0] OP_DEPTH = 8'h09;
  localparam logic [7:0] OP_ECO   = 8'h14;
  localparam logic [7:0] OP_IF    = 8'h20;
  localparam logic [7:0] OP_SET   = 8'h23;
  localparam logic [7:0] OP_GET   = 8'h24;
  localparam logic [7:0] OP_PEN   = 8'h30;
  localparam logic [7:0] OP_MOVE  = 8'h32;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  typedef enum logic [3:0] {
    EV_BOOT     = 4'd0,
    EV_PRINT    = 4'd1,
    EV_MOVE     = 4'd2,
    EV_STATS    = 4'd3,
    EV_PURGE    = 4'd4,
    EV_ECO      = 4'd5,
    EV_IF       = 4'd6,
    EV_SET      = 4'd7,
    EV_GET      = 4'd8,
    EV_PEN      = 4'd9,
    EV_HALT     = 4'd10,
    EV_UNKNOWN  = 4'd11,
    EV_OVERFLOW = 4'd12
  } event_t;

  // what a stack cell loads on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,
    CELL_UP   = 2'd2
  } cell_op_t;

  typedef struct packed {
    event_t                    event_res;
    logic signed [DATA_W-1:0]  value;
    logic [DEPTH_W-1:0]        depth;
    logic [BYTE_W-1:0]         opcode;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/bse_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_in_if
// Program byte channel: valid/ready with code byte and program start flag.
// ----------------------------------------------------------------------------
interface bse_in_if;
  import bse_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              program_start;

  modport source (output valid, output code_byte, output program_start, input ready);
  modport sink   (input valid, input code_byte, input program_start, output ready);
endinterface
`default_nettype wire

// ===== hdl/bse_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_out_if
// Event channel: valid/ready with event code, value, depth and opcode.
// ----------------------------------------------------------------------------
interface bse_out_if;
  import bse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [3:0]               event_res;
  logic signed [DATA_W-1:0] value;
  logic [DEPTH_W-1:0]       depth;
  logic [BYTE_W-1:0]        opcode;

  modport source (output valid, output event_res, output value, output depth,
                  output opcode, input ready);
  modport sink   (input valid, input event_res, input value, input depth,
                  input opcode, output ready);
endinterface
`default_nettype wire

// ===== hdl/bse_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_cell
// One stack entry: holds, takes the entry above or takes the entry below.
// ----------------------------------------------------------------------------
module bse_cell (
  input  wire                           clk,
  input  bse_pkg::cell_op_t             op,
  input  wire [bse_pkg::DATA_W-1:0]     upper,
  input  wire [bse_pkg::DATA_W-1:0]     lower,
  output logic [bse_pkg::DATA_W-1:0]    entry
);
  import bse_pkg::*;

  logic [DATA_W-1:0] entry_next;

  always_comb begin
    case (op)
      CELL_DOWN: entry_next = upper;
      CELL_UP:   entry_next = lower;
      default:   entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

// ===== hdl/bse_out_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bse_out_skid
// Two-entry output buffer: main register plus skid register.
// ----------------------------------------------------------------------------
module bse_out_skid (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  bse_pkg::res_t       res,
  output logic                space,
  bse_out_if.source           report
);
  import bse_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main;
  res_t skid;
  logic take;

  assign take  = main_valid & report.ready;
  assign space = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= push;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        main <= skid;
      end else if (push) begin
        main <= res;
      end
    end else if (push) begin
      if (!main_valid) begin
        main <= res;
      end else begin
        skid <= res;
      end
    end
  end

  assign report.valid     = main_valid;
  assign report.event_res = main.event_res;
  assign report.value     = main.value;
  assign report.depth     = main.depth;
  assign report.opcode    = main.opcode;

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without a main entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into a full output buffer");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (main_valid && !report.ready) |=> (main_valid && $stable(main)))
    else $error("stalled event changed before it was taken");
`endif

endmodule
`default_nettype wire

// ===== hdl/bytecode_stack_executor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_stack_executor
// Byte-coded stack machine with the stack held in a chain of shift cells.
// ----------------------------------------------------------------------------
// usage
//   prog   : one program byte per request (code_byte, program_start),
//            valid/ready; program_start clears halt and a pending immediate
//            before the byte is taken, the stack is kept
//   report : at most one event per byte (event_res, value, depth, opcode)
//   throughput: one byte per cycle while prog.ready is high; every byte
//            acts in the cycle it is accepted, the stack cells shift up or
//            down in that same edge
//   stall: report is buffered by a main register and a skid register;
//            prog.ready drops only while both hold events, so a stalled
//            receiver lets at most one more event in before back-pressure
//   reset: synchronous rst empties the stack count, clears halt and any
//            pending immediate and drops buffered events; stack cells
//            themselves are not cleared, entries above the count are unused
// ----------------------------------------------------------------------------
module bytecode_stack_executor (
  input  wire        clk,
  input  wire        rst,
  bse_in_if.sink     prog,
  bse_out_if.source  report
);
  import bse_pkg::*;

  // control state
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [LEFT_W-1:0] left;
  logic [LEFT_W-1:0] left_next;
  logic              halted;
  logic              halted_next;

  // immediate gathering, shifted in little-endian order
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] acc_next;

  // stack chain, cell 0 is top of stack
  logic [DATA_W-1:0] stack_value [STACK_DEPTH];
  cell_op_t          cell_op     [STACK_DEPTH];
  logic [DATA_W-1:0] top_load;

  logic              accept;
  logic              space;
  logic              halted_eff;
  logic [LEFT_W-1:0] left_eff;
  logic              do_push;
  logic              do_pop;
  logic              do_merge;
  logic              res_valid;
  res_t              res;
  logic [BYTE_W-1:0] b;

  assign b          = prog.code_byte;
  assign prog.ready = space;
  assign accept     = prog.valid & space;

  // byte decode and next-state
  always_comb begin
    halted_eff  = halted & ~prog.program_start;
    left_eff    = prog.program_start ? '0 : left;
    halted_next = halted_eff;
    left_next   = left_eff;
    acc_next    = acc;
    count_next  = count;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    do_merge    = 1'b0;
    top_load    = acc;
    res_valid   = 1'b0;
    res.event_res = EV_BOOT;
    res.value     = '0;
    res.opcode    = b;

    if (!halted_eff) begin
      if (left_eff != '0) begin
        // immediate byte, never decoded as an opcode
        acc_next  = {b, acc[DATA_W-1:BYTE_W]};
        left_next = left_eff - LEFT_W'(1);
        if (left_eff == LEFT_W'(1)) begin
          if (count == CNT_W'(STACK_DEPTH)) begin
            res_valid     = 1'b1;
            res.event_res = EV_OVERFLOW;
            res.opcode    = OP_PUSH;
          end else begin
            do_push    = 1'b1;
            top_load   = acc_next;
            count_next = count + CNT_W'(1);
          end
        end
      end else begin
        case (b)
          OP_BOOT: begin
            res_valid = 1'b1;
            res.event_res = EV_BOOT;
          end
          OP_PUSH: begin
            acc_next  = '0;
            left_next = LEFT_W'(IMM_BYTES);
          end
          OP_ADD, OP_SUB: begin
            if (count >= CNT_W'(2)) begin
              do_merge   = 1'b1;
              top_load   = (b == OP_ADD) ? stack_value[1] + stack_value[0]
                                         : stack_value[1] - stack_value[0];
              count_next = count - CNT_W'(1);
            end
          end
          OP_PEEK: begin
            if (count != '0) begin
              res_valid     = 1'b1;
              res.event_res = EV_PRINT;
              res.value     = stack_value[0];
            end
          end
          OP_MOVE: begin
            if (count != '0) begin
              res_valid     = 1'b1;
              res.event_res = EV_MOVE;
              res.value     = stack_value[0];
              do_pop        = 1'b1;
              count_next    = count - CNT_W'(1);
            end
          end
          OP_DEPTH: begin
            res_valid = 1'b1;
            res.event_res = EV_STATS;
          end
          OP_CLEAR: begin
            res_valid     = 1'b1;
            res.event_res = EV_PURGE;
            count_next    = '0;
          end
          OP_ECO: begin
            res_valid = 1'b1;
            res.event_res = EV_ECO;
          end
          OP_IF: begin
            res_valid = 1'b1;
            res.event_res = EV_IF;
          end
          OP_SET: begin
            res_valid = 1'b1;
            res.event_res = EV_SET;
          end
          OP_GET: begin
            res_valid = 1'b1;
            res.event_res = EV_GET;
          end
          OP_PEN: begin
            res_valid = 1'b1;
            res.event_res = EV_PEN;
          end
          OP_HALT: begin
            res_valid     = 1'b1;
            res.event_res = EV_HALT;
            halted_next   = 1'b1;
          end
          default: begin
            // unknown opcode stops the machine
            res_valid     = 1'b1;
            res.event_res = EV_UNKNOWN;
            halted_next   = 1'b1;
          end
        endcase
      end
    end

    // depth field is the count after this byte, kept to 7 bits
    res.depth = DEPTH_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      left   <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      count  <= count_next;
      left   <= left_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= acc_next;
    end
  end

  // chain of cells: push shifts down, pop shifts up, add/sub loads the
  // result into the top cell and shifts the rest up by one
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] upper;
    logic [DATA_W-1:0] lower;

    if (i == 0) begin : g_top
      assign upper = top_load;
    end else begin : g_mid
      assign upper = stack_value[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign lower = stack_value[i];
    end else begin : g_below
      assign lower = stack_value[i+1];
    end

    always_comb begin
      if (!accept) begin
        cell_op[i] = CELL_HOLD;
      end else if (do_push) begin
        cell_op[i] = CELL_DOWN;
      end else if (do_pop) begin
        cell_op[i] = CELL_UP;
      end else if (do_merge) begin
        cell_op[i] = (i == 0) ? CELL_DOWN : CELL_UP;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    bse_cell u_cell (
      .clk   (clk),
      .op    (cell_op[i]),
      .upper (upper),
      .lower (lower),
      .entry (stack_value[i])
    );
  end

  // event buffer toward report
  bse_out_skid u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (accept & res_valid),
    .res    (res),
    .space  (space),
    .report (report)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  a_halted_keeps_stack: assert property (@(posedge clk) disable iff (rst)
    (accept && halted && !prog.program_start) |=> $stable(count) && halted)
    else $error("halted machine changed its state");

  a_immediate_no_halt: assert property (@(posedge clk) disable iff (rst)
    (accept && !halted && !prog.program_start && left != '0) |=> !halted)
    else $error("immediate byte decoded as an opcode");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_bytecode_stack_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bytecode_stack_executor
// Self-checking bench for the byte-coded stack machine. Program bytes go in
// on the prog channel. A predictor in the bench keeps its own stack, pending
// immediate and halt flag, and queues the event each accepted byte should
// raise. Events seen on the report channel are compared with that queue in
// order. Stimulus: a directed program, random programs, a full-stack run with
// a long receiver stall, then two more random runs; three idling mixes in all.
// ----------------------------------------------------------------------------
module tb_bytecode_stack_executor;
  import bse_pkg::*;

  // generous watchdog bound on the length of the whole run
  localparam int CYCLE_LIMIT  = 300000;
  // drain wait after the last owed event, to catch stray events
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;

  bse_in_if  prog_if ();
  bse_out_if report_if ();

  bytecode_stack_executor dut (
    .clk    (clk),
    .rst    (rst),
    .prog   (prog_if),
    .report (report_if)
  );

  // predictor state: mirror of the machine
  logic [DATA_W-1:0] stack_mirror [STACK_DEPTH];
  int unsigned       depth_mirror   = 0;
  logic [DATA_W-1:0] imm_mirror     = '0;
  int unsigned       imm_left_mirror = 0;
  bit                halted_mirror  = 1'b0;

  // events still owed by the block, oldest first
  res_t pending_events [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;   // receiver hold-off, counted down by the receiver
  int fail_count    = 0;
  int cycle_count   = 0;
  int live_items    = 0;   // bytes that the machine actually acted on

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic void queue_event(event_t ev, logic [DATA_W-1:0] val,
                                      logic [BYTE_W-1:0] op);
    res_t r;
    r.event_res = ev;
    r.value     = val;
    r.depth     = DEPTH_W'(depth_mirror);
    r.opcode    = op;
    pending_events = {pending_events, r};
  endfunction

  function automatic void predict_byte(logic [BYTE_W-1:0] b, bit start);
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    // program start drops halt and any half-gathered immediate, stack stays
    if (start) begin
      halted_mirror   = 1'b0;
      imm_left_mirror = 0;
      imm_mirror      = '0;
    end
    if (halted_mirror) return;
    live_items++;

    // immediate bytes are never decoded, little-endian gather
    if (imm_left_mirror != 0) begin
      imm_mirror = imm_mirror |
                   (DATA_W'(b) << (BYTE_W * (IMM_BYTES - imm_left_mirror)));
      imm_left_mirror--;
      if (imm_left_mirror == 0) begin
        if (depth_mirror >= STACK_DEPTH) begin
          // push onto a full stack is dropped
          queue_event(EV_OVERFLOW, '0, OP_PUSH);
        end else begin
          stack_mirror[depth_mirror] = imm_mirror;
          depth_mirror++;
        end
      end
      return;
    end

    case (b)
      OP_BOOT:  queue_event(EV_BOOT, '0, b);
      OP_PUSH: begin
        imm_mirror      = '0;
        imm_left_mirror = IMM_BYTES;
      end
      OP_ADD, OP_SUB: begin
        // fewer than two values: nothing happens
        if (depth_mirror >= 2) begin
          rhs = stack_mirror[depth_mirror-1];
          lhs = stack_mirror[depth_mirror-2];
          depth_mirror--;
          stack_mirror[depth_mirror-1] = (b == OP_ADD) ? lhs + rhs : lhs - rhs;
        end
      end
      OP_PEEK: begin
        if (depth_mirror != 0) queue_event(EV_PRINT, stack_mirror[depth_mirror-1], b);
      end
      OP_MOVE: begin
        if (depth_mirror != 0) begin
          depth_mirror--;
          queue_event(EV_MOVE, stack_mirror[depth_mirror], b);
        end
      end
      OP_DEPTH: queue_event(EV_STATS, '0, b);
      OP_CLEAR: begin
        depth_mirror = 0;
        queue_event(EV_PURGE, '0, b);
      end
      OP_ECO:   queue_event(EV_ECO, '0, b);
      OP_IF:    queue_event(EV_IF, '0, b);
      OP_SET:   queue_event(EV_SET, '0, b);
      OP_GET:   queue_event(EV_GET, '0, b);
      OP_PEN:   queue_event(EV_PEN, '0, b);
      OP_HALT: begin
        halted_mirror = 1'b1;
        queue_event(EV_HALT, '0, b);
      end
      default: begin
        // anything else is unknown and stops the machine
        halted_mirror = 1'b1;
        queue_event(EV_UNKNOWN, '0, b);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one request per call, random gaps before it
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [BYTE_W-1:0] b, input bit start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      prog_if.valid <= 1'b0;
      @(negedge clk);
    end
    prog_if.valid         <= 1'b1;
    prog_if.code_byte     <= b;
    prog_if.program_start <= start;
    do @(posedge clk); while (!prog_if.ready);
    // accepted at this edge
    predict_byte(b, start);
  endtask

  task automatic push_word(input logic [DATA_W-1:0] w, input bit start);
    offer_byte(OP_PUSH, start);
    for (int i = 0; i < IMM_BYTES; i++) offer_byte(w[BYTE_W*i +: BYTE_W], 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random ready, or a counted hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      report_if.ready <= 1'b0;
      hold_left--;
    end else begin
      report_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // event checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst && report_if.valid && report_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event %0d opcode %h", report_if.event_res, report_if.opcode);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (report_if.event_res !== want.event_res) begin
          $error("event_res: expected %0d, actual %0d", want.event_res,
                 report_if.event_res);
          fail_count++;
        end
        if (report_if.value !== want.value) begin
          $error("value: expected %h, actual %h", want.value, report_if.value);
          fail_count++;
        end
        if (report_if.depth !== want.depth) begin
          $error("depth: expected %0d, actual %0d", want.depth, report_if.depth);
          fail_count++;
        end
        if (report_if.opcode !== want.opcode) begin
          $error("opcode: expected %h, actual %h", want.opcode, report_if.opcode);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bytecode_stack_executor test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // push values biased toward the wrap corners
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return DATA_W'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // restart a halted machine most of the time, rarely restart a live one
  function automatic bit pick_start();
    if (halted_mirror) return ($urandom_range(3) != 0);
    return ($urandom_range(15) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // every opcode at least once plus corner cases
  task automatic test_directed_opcodes();
    offer_byte(OP_BOOT, 1'b1);
    offer_byte(OP_PEEK, 1'b0);              // print on empty stack: no event
    offer_byte(OP_MOVE, 1'b0);              // move on empty stack: no event
    offer_byte(OP_ADD, 1'b0);               // add with nothing held
    push_word(32'hFFFF_FFFF, 1'b0);
    offer_byte(OP_SUB, 1'b0);               // sub with one value held
    push_word(32'h8000_0000, 1'b0);
    offer_byte(OP_ADD, 1'b0);               // wraps to 7fffffff
    offer_byte(OP_PEEK, 1'b0);
    offer_byte(OP_DEPTH, 1'b0);
    offer_byte(OP_ECO, 1'b0);
    offer_byte(OP_IF, 1'b0);
    offer_byte(OP_SET, 1'b0);
    offer_byte(OP_GET, 1'b0);
    offer_byte(OP_PEN, 1'b0);
    offer_byte(OP_MOVE, 1'b0);
    offer_byte(OP_CLEAR, 1'b0);
    offer_byte(OP_HALT, 1'b0);
    offer_byte(OP_PEEK, 1'b0);              // ignored while halted
    offer_byte(OP_PUSH, 1'b1);
    offer_byte(8'h5A, 1'b0);
    offer_byte(OP_DEPTH, 1'b1);             // start drops the half-done push
    offer_byte(8'hAB, 1'b0);                // unknown opcode halts
    offer_byte(OP_BOOT, 1'b1);
  endtask

  // fill past the top with the receiver held off, then drain the stack
  task automatic test_full_stack_stall();
    send_idle_pct = 0;
    offer_byte(OP_CLEAR, 1'b1);
    // long stall: events pile up and prog.ready must drop
    hold_left = HOLD_CYCLES;
    repeat (3) offer_byte(OP_DEPTH, 1'b0);
    for (int i = 0; i < STACK_DEPTH + 4; i++) push_word(pick_word(), 1'b0);
    offer_byte(OP_PEEK, 1'b0);
    for (int i = 0; i < STACK_DEPTH + 2; i++) offer_byte(OP_MOVE, 1'b0);
    offer_byte(OP_DEPTH, 1'b0);
  endtask

  // random programs: mostly well-formed, some noise and broken pushes
  task automatic test_random_programs(input int n_items);
    int first;
    int kind;
    int cnt;
    logic [BYTE_W-1:0] msg_ops [8];
    msg_ops = '{OP_BOOT, OP_DEPTH, OP_ECO, OP_IF, OP_SET, OP_GET, OP_PEN, OP_CLEAR};
    first = live_items;
    while (live_items - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        push_word(pick_word(), pick_start());
      end else if (kind < 50) begin
        offer_byte($urandom_range(1) ? OP_ADD : OP_SUB, pick_start());
      end else if (kind < 60) begin
        offer_byte($urandom_range(1) ? OP_PEEK : OP_MOVE, pick_start());
      end else if (kind < 70) begin
        offer_byte(msg_ops[$urandom_range(7)], pick_start());
      end else if (kind < 75) begin
        // halt, or a random byte that may stop the machine, then up to three more random bytes
        offer_byte($urandom_range(2) != 0 ? OP_HALT : BYTE_W'($urandom_range(255)),
                   pick_start());
        cnt = $urandom_range(3);
        repeat (cnt) offer_byte(BYTE_W'($urandom_range(255)), 1'b0);
      end else if (kind < 85) begin
        offer_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
      end else if (kind < 93) begin
        // push cut short by a program start
        offer_byte(OP_PUSH, pick_start());
        cnt = $urandom_range(IMM_BYTES - 1);
        repeat (cnt) offer_byte(BYTE_W'($urandom_range(255)), 1'b0);
        offer_byte(msg_ops[$urandom_range(7)], 1'b1);
      end else begin
        // burst of pushes drives the stack toward full
        cnt = $urandom_range(20, 8);
        push_word(pick_word(), pick_start());
        repeat (cnt - 1) push_word(pick_word(), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    prog_if.valid         = 1'b0;
    prog_if.code_byte     = '0;
    prog_if.program_start = 1'b0;
    report_if.ready       = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 80;
    test_directed_opcodes();
    test_random_programs(520);

    test_full_stack_stall();

    send_idle_pct = 80;
    recv_idle_pct = 31;
    test_random_programs(520);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_programs(520);

    @(negedge clk);
    prog_if.valid <= 1'b0;

    // wait for every owed event, then wait on for stray ones
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("bytecode_stack_executor test passed");
    end else begin
      $display("bytecode_stack_executor test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bse_pkg.sv
hdl/bse_in_if.sv
hdl/bse_out_if.sv
hdl/bse_cell.sv
hdl/bse_out_skid.sv
hdl/bytecode_stack_executor.sv
verif/tb_bytecode_stack_executor.sv
